// ===== sv/sobel_pkg.sv =====
// Shared constants and types for the 3x3 Sobel gradient block.
// Used by the channel interfaces and the top level; no dependencies.
package sobel_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;

  // Column and row indexes, and sizes that must also hold the maximum itself.
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int COL_SIZE_W = $clog2(MAX_WIDTH + 1);
  localparam int ROW_SIZE_W = $clog2(MAX_HEIGHT + 1);

  localparam int PIXEL_W      = 8;
  localparam int GRAD_W       = 11;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;
  localparam int MIN_SIZE     = 3;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 13'd480;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT,
    REG_VERTICAL_MODE,
    REG_ABSOLUTE_MODE
  } reg_index_t;

  typedef logic [PIXEL_W-1:0]        pixel_t;
  typedef logic signed [GRAD_W-1:0]  grad_t;
  typedef logic [2*PIXEL_W-1:0]      line_word_t;

endpackage

// ===== sv/sobel_pixel_if.sv =====
// Input channel of the Sobel block: one source pixel per transfer.
// Depends on sobel_pkg.
interface sobel_pixel_if;
  logic              valid;
  logic              ready;
  sobel_pkg::pixel_t pixel;
  logic              frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

// ===== sv/sobel_grad_if.sv =====
// Result channel of the Sobel block: one gradient with row and frame flags per transfer.
// Depends on sobel_pkg.
interface sobel_grad_if;
  logic             valid;
  logic             ready;
  sobel_pkg::grad_t gradient;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output gradient, output row_end, output frame_end,
                  input ready);
  modport sink   (input valid, input gradient, input row_end, input frame_end,
                  output ready);
endinterface

// ===== sv/sobel_gradient_3x3.sv =====
// Top level of the 3x3 Sobel gradient block: position counters, line memory,
// window registers, gradient datapath and APB register file. Depends on sobel_pkg
// and the sobel_pixel_if / sobel_grad_if interfaces.
//
//   channel    kind       direction  carries
//   pix_in     valid/rdy  in         pixel, frame_start
//   grad_out   valid/rdy  out        gradient, row_end, frame_end
//   APB        psel/pen   in/out     image_width, image_height, vertical_mode, absolute_mode
//
// One pixel per clock while the output is not stalled; a result passes the input register
// and then the output register. The input register reads the line memory (one read port,
// registered data); the gradient is formed from it into the output register when it advances.
// rst is synchronous; it clears counters, window and valid flags and reloads the register reset values.
// A stalled output holds the input register and blocks pix_in; pixels that give
// no result pass the input register even while the output is stalled.
module sobel_gradient_3x3 (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sobel_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [sobel_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [sobel_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  sobel_pixel_if.sink                         pix_in,
  sobel_grad_if.source                        grad_out
);

  // Configuration registers
  logic [sobel_pkg::WIDTH_REG_W-1:0]  image_width;
  logic [sobel_pkg::HEIGHT_REG_W-1:0] image_height;
  logic                               vertical_mode;
  logic                               absolute_mode;

  sobel_pkg::reg_index_t reg_sel;
  logic                  cfg_write;

  assign pready    = 1'b1;
  assign reg_sel   = sobel_pkg::reg_index_t'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= sobel_pkg::WIDTH_RESET;
      image_height  <= sobel_pkg::HEIGHT_RESET;
      vertical_mode <= 1'b0;
      absolute_mode <= 1'b0;
    end else if (cfg_write) begin
      case (reg_sel)
        sobel_pkg::REG_IMAGE_WIDTH:   image_width   <= pwdata[sobel_pkg::WIDTH_REG_W-1:0];
        sobel_pkg::REG_IMAGE_HEIGHT:  image_height  <= pwdata[sobel_pkg::HEIGHT_REG_W-1:0];
        sobel_pkg::REG_VERTICAL_MODE: vertical_mode <= pwdata[0];
        sobel_pkg::REG_ABSOLUTE_MODE: absolute_mode <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sobel_pkg::REG_IMAGE_WIDTH:   prdata = sobel_pkg::APB_DATA_W'(image_width);
      sobel_pkg::REG_IMAGE_HEIGHT:  prdata = sobel_pkg::APB_DATA_W'(image_height);
      sobel_pkg::REG_VERTICAL_MODE: prdata = sobel_pkg::APB_DATA_W'(vertical_mode);
      sobel_pkg::REG_ABSOLUTE_MODE: prdata = sobel_pkg::APB_DATA_W'(absolute_mode);
      default:                      prdata = '0;
    endcase
  end

  // Effective frame size, clamped to the supported range
  logic [sobel_pkg::COL_SIZE_W-1:0] w_eff;
  logic [sobel_pkg::ROW_SIZE_W-1:0] h_eff;

  always_comb begin
    if (32'(image_width) < sobel_pkg::MIN_SIZE) begin
      w_eff = sobel_pkg::COL_SIZE_W'(sobel_pkg::MIN_SIZE);
    end else if (32'(image_width) > sobel_pkg::MAX_WIDTH) begin
      w_eff = sobel_pkg::COL_SIZE_W'(sobel_pkg::MAX_WIDTH);
    end else begin
      w_eff = sobel_pkg::COL_SIZE_W'(image_width);
    end
    if (32'(image_height) < sobel_pkg::MIN_SIZE) begin
      h_eff = sobel_pkg::ROW_SIZE_W'(sobel_pkg::MIN_SIZE);
    end else if (32'(image_height) > sobel_pkg::MAX_HEIGHT) begin
      h_eff = sobel_pkg::ROW_SIZE_W'(sobel_pkg::MAX_HEIGHT);
    end else begin
      h_eff = sobel_pkg::ROW_SIZE_W'(image_height);
    end
  end

  // Position of the incoming pixel
  logic [sobel_pkg::COL_W-1:0]      col;
  logic [sobel_pkg::ROW_W-1:0]      row;
  logic [sobel_pkg::COL_SIZE_W-1:0] col_pos;
  logic [sobel_pkg::ROW_SIZE_W-1:0] row_pos;
  logic [sobel_pkg::COL_W-1:0]      col_next;
  logic [sobel_pkg::ROW_W-1:0]      row_next;
  logic                             last_col;
  logic                             last_row;
  logic                             in_take;

  assign in_take = pix_in.valid && pix_in.ready;

  always_comb begin
    col_pos = pix_in.frame_start ? '0 : sobel_pkg::COL_SIZE_W'(col);
    row_pos = pix_in.frame_start ? '0 : sobel_pkg::ROW_SIZE_W'(row);
    // wrap a position left beyond a shrunk size
    if (col_pos >= w_eff) begin
      col_pos = '0;
      row_pos = row_pos + 1'b1;
    end
    if (row_pos >= h_eff) begin
      row_pos = '0;
    end
    last_col = (col_pos == w_eff - 1'b1);
    last_row = (row_pos == h_eff - 1'b1);
    col_next = last_col ? '0 : col_pos[sobel_pkg::COL_W-1:0] + 1'b1;
    if (last_col) begin
      row_next = last_row ? '0 : row_pos[sobel_pkg::ROW_W-1:0] + 1'b1;
    end else begin
      row_next = row_pos[sobel_pkg::ROW_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (in_take) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Input register
  logic                        a_valid;
  sobel_pkg::pixel_t           a_pixel;
  logic [sobel_pkg::COL_W-1:0] a_col;
  logic                        a_emit;
  logic                        a_row_end;
  logic                        a_frame_end;
  logic                        out_valid;
  logic                        advance;

  assign advance      = a_valid && (!a_emit || !out_valid || grad_out.ready);
  assign pix_in.ready = !a_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_pixel     <= pix_in.pixel;
      a_col       <= col_pos[sobel_pkg::COL_W-1:0];
      a_emit      <= (col_pos >= 2) && (row_pos >= 2);
      a_row_end   <= last_col;
      a_frame_end <= last_col && last_row;
    end
  end

  // Line memory: upper byte two rows up, lower byte one row up
  sobel_pkg::line_word_t line_mem [sobel_pkg::MAX_WIDTH];
  sobel_pkg::line_word_t mem_q;
  sobel_pkg::line_word_t byp_data;
  sobel_pkg::line_word_t line_word;
  sobel_pkg::line_word_t wr_word;
  logic                  byp;
  sobel_pkg::pixel_t     t2;
  sobel_pkg::pixel_t     m2;

  assign line_word = byp ? byp_data : mem_q;
  assign t2        = line_word[2*sobel_pkg::PIXEL_W-1:sobel_pkg::PIXEL_W];
  assign m2        = line_word[sobel_pkg::PIXEL_W-1:0];
  assign wr_word   = {m2, a_pixel};

  always_ff @(posedge clk) begin
    if (advance) begin
      line_mem[a_col] <= wr_word;
    end
    if (in_take) begin
      mem_q <= line_mem[col_pos[sobel_pkg::COL_W-1:0]];
    end
  end

  // forward the word written at the same edge as a read of that column
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (in_take) begin
      byp <= advance && (a_col == col_pos[sobel_pkg::COL_W-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      byp_data <= wr_word;
    end
  end

  // Window: columns c-2 (win[0..2]) and c-1 (win[3..5]), top to bottom
  sobel_pkg::pixel_t win [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        win[i] <= '0;
      end
    end else if (advance) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= t2;
      win[4] <= m2;
      win[5] <= a_pixel;
    end
  end

  // Gradient
  logic [11:0]        sum_pos;
  logic [11:0]        sum_neg;
  logic signed [11:0] diff;
  logic signed [11:0] grad_full;

  always_comb begin
    if (vertical_mode) begin
      sum_pos = 12'(win[2]) + {3'b0, win[5], 1'b0} + 12'(a_pixel);
      sum_neg = 12'(win[0]) + {3'b0, win[3], 1'b0} + 12'(t2);
    end else begin
      sum_pos = 12'(t2) + {3'b0, m2, 1'b0} + 12'(a_pixel);
      sum_neg = 12'(win[0]) + {3'b0, win[1], 1'b0} + 12'(win[2]);
    end
    diff      = $signed(sum_pos) - $signed(sum_neg);
    grad_full = (absolute_mode && diff < 0) ? -diff : diff;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && a_emit) begin
      out_valid <= 1'b1;
    end else if (grad_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && a_emit) begin
      grad_out.gradient  <= grad_full[sobel_pkg::GRAD_W-1:0];
      grad_out.row_end   <= a_row_end;
      grad_out.frame_end <= a_frame_end;
    end
  end

  assign grad_out.valid = out_valid;

endmodule

// ===== dv/sobel_gradient_3x3_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for sobel_gradient_3x3: pixel frames in, gradients checked
// against an in-bench predictor. Depends on sobel_pkg, sobel_pixel_if and sobel_grad_if.
module sobel_gradient_3x3_test;

  localparam int HALF_PERIOD   = 2;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int MAX_REPORTS   = 10;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;

  typedef struct packed {
    sobel_pkg::grad_t gradient;
    logic             row_end;
    logic             frame_end;
  } grad_result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sobel_pkg::APB_ADDR_W-1:0] paddr;
  logic [sobel_pkg::APB_DATA_W-1:0] pwdata;
  logic [sobel_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  sobel_pixel_if pix_ch ();
  sobel_grad_if  grad_ch ();

  sobel_gradient_3x3 dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .pix_in   (pix_ch),
    .grad_out (grad_ch)
  );

  // Register mirror
  logic [sobel_pkg::WIDTH_REG_W-1:0]  cfg_width    = sobel_pkg::WIDTH_RESET;
  logic [sobel_pkg::HEIGHT_REG_W-1:0] cfg_height   = sobel_pkg::HEIGHT_RESET;
  logic                               cfg_vertical = 1'b0;
  logic                               cfg_absolute = 1'b0;

  // Predictor state: two stored lines, two window columns, raster position
  bit [sobel_pkg::PIXEL_W-1:0] upper_line [sobel_pkg::MAX_WIDTH];
  bit [sobel_pkg::PIXEL_W-1:0] middle_line [sobel_pkg::MAX_WIDTH];
  bit [sobel_pkg::PIXEL_W-1:0] window_px [6];
  int unsigned col_pos = 0;
  int unsigned row_pos = 0;

  grad_result_t pending_grads [$];

  int  mismatch_count = 0;
  int  sender_idle = 0;
  int  receiver_idle = 0;
  int  hold_off_cycles = 0;
  bit  restart_frame = 1'b0;
  int unsigned cycle_count = 0;

  always begin
    #(HALF_PERIOD) clk = 1'b1;
    #(HALF_PERIOD) clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned eff_size(input int unsigned v, input int unsigned hi);
    if (v < sobel_pkg::MIN_SIZE) return sobel_pkg::MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int idle_length(input int level);
    if (level >= 2 && $urandom_range(0, 9) == 0) return $urandom_range(10, 50);
    return $urandom_range(1, 3);
  endfunction

  function automatic void flag_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("ERROR @%0d: %s", cycle_count, msg);
  endfunction

  // Advance the position, update lines and window, queue a gradient for interior pixels.
  function automatic void predict_gradient(input sobel_pkg::pixel_t px, input logic start);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int t0, m0, b0, t1, b1, t2, m2, b2, g;
    logic last_col;
    logic last_row;
    grad_result_t res;
    w = eff_size(32'(cfg_width), sobel_pkg::MAX_WIDTH);
    h = eff_size(32'(cfg_height), sobel_pkg::MAX_HEIGHT);
    if (start) begin
      col_pos = 0;
      row_pos = 0;
    end
    // a shrunk size can leave the position outside the frame
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    c = col_pos;
    t2 = int'(upper_line[c]);
    m2 = int'(middle_line[c]);
    b2 = int'(px);
    upper_line[c] = m2[sobel_pkg::PIXEL_W-1:0];
    middle_line[c] = px;
    t0 = int'(window_px[0]);
    m0 = int'(window_px[1]);
    b0 = int'(window_px[2]);
    t1 = int'(window_px[3]);
    b1 = int'(window_px[5]);
    last_col = (c == w - 1);
    last_row = (row_pos == h - 1);
    if (c >= 2 && row_pos >= 2) begin
      if (cfg_vertical) g = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
      else g = (t2 + 2 * m2 + b2) - (t0 + 2 * m0 + b0);
      if (cfg_absolute && g < 0) g = -g;
      res.gradient = g[sobel_pkg::GRAD_W-1:0];
      res.row_end = last_col;
      res.frame_end = last_col && last_row;
      pending_grads.push_back(res);
    end
    window_px[0] = window_px[3];
    window_px[1] = window_px[4];
    window_px[2] = window_px[5];
    window_px[3] = t2[sobel_pkg::PIXEL_W-1:0];
    window_px[4] = m2[sobel_pkg::PIXEL_W-1:0];
    window_px[5] = px;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos = c + 1;
    end
  endfunction

  task automatic apb_write(input sobel_pkg::reg_index_t idx,
                           input logic [sobel_pkg::APB_DATA_W-1:0] value);
    int unsigned old_w;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel <= 1'b0;
    penable <= 1'b0;
    old_w = eff_size(32'(cfg_width), sobel_pkg::MAX_WIDTH);
    case (idx)
      sobel_pkg::REG_IMAGE_WIDTH:   cfg_width = value[sobel_pkg::WIDTH_REG_W-1:0];
      sobel_pkg::REG_IMAGE_HEIGHT:  cfg_height = value[sobel_pkg::HEIGHT_REG_W-1:0];
      sobel_pkg::REG_VERTICAL_MODE: cfg_vertical = value[0];
      sobel_pkg::REG_ABSOLUTE_MODE: cfg_absolute = value[0];
      default: ;
    endcase
    // a wider line has never-written entries: start a fresh frame
    if (eff_size(32'(cfg_width), sobel_pkg::MAX_WIDTH) > old_w) restart_frame = 1'b1;
    @(posedge clk);
  endtask

  task automatic check_register(input sobel_pkg::reg_index_t idx);
    logic [sobel_pkg::APB_DATA_W-1:0] got;
    logic [sobel_pkg::APB_DATA_W-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      sobel_pkg::REG_IMAGE_WIDTH:   want = sobel_pkg::APB_DATA_W'(cfg_width);
      sobel_pkg::REG_IMAGE_HEIGHT:  want = sobel_pkg::APB_DATA_W'(cfg_height);
      sobel_pkg::REG_VERTICAL_MODE: want = sobel_pkg::APB_DATA_W'(cfg_vertical);
      default:                      want = sobel_pkg::APB_DATA_W'(cfg_absolute);
    endcase
    if (got !== want)
      flag_error($sformatf("register %s read %0h, expected %0h", idx.name(), got, want));
    @(posedge clk);
  endtask

  // Offer one pixel, hold it until the transfer, then maybe leave a gap.
  task automatic push_pixel(input sobel_pkg::pixel_t px, input logic fs);
    logic start;
    start = fs | restart_frame;
    restart_frame = 1'b0;
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    pix_ch.frame_start <= start;
    do @(posedge clk); while (pix_ch.ready !== 1'b1);
    predict_gradient(px, start);
    if (sender_idle != 0 && $urandom_range(0, 99) < 30) begin
      pix_ch.valid <= 1'b0;
      repeat (idle_length(sender_idle)) @(posedge clk);
    end
  endtask

  task automatic push_random_pixels(input int count, input logic first_start);
    for (int k = 0; k < count; k++)
      push_pixel(sobel_pkg::pixel_t'($urandom_range(0, 255)), first_start && k == 0);
  endtask

  // Drop valid, wait for every queued gradient, then let the pipeline empty.
  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    while (pending_grads.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_checker
    grad_result_t want;
    if (rst === 1'b0 && grad_ch.valid === 1'b1 && grad_ch.ready === 1'b1) begin
      if (pending_grads.size() == 0) begin
        flag_error($sformatf("unexpected gradient %0d", grad_ch.gradient));
      end else begin
        want = pending_grads.pop_front();
        if (grad_ch.gradient !== want.gradient)
          flag_error($sformatf("gradient %0d, expected %0d", grad_ch.gradient, want.gradient));
        if (grad_ch.row_end !== want.row_end)
          flag_error($sformatf("row_end %b, expected %b", grad_ch.row_end, want.row_end));
        if (grad_ch.frame_end !== want.frame_end)
          flag_error($sformatf("frame_end %b, expected %b", grad_ch.frame_end,
                               want.frame_end));
      end
    end
  end

  initial begin : result_receiver
    int stall_left;
    stall_left = 0;
    grad_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        grad_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (stall_left > 0) begin
        grad_ch.ready <= 1'b0;
        stall_left--;
      end else if (receiver_idle != 0 && $urandom_range(0, 99) < 20) begin
        grad_ch.ready <= 1'b0;
        stall_left = idle_length(receiver_idle) - 1;
      end else begin
        grad_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_register_access();
    wait_idle();
    for (int i = 0; i < 4; i++) check_register(sobel_pkg::reg_index_t'(i));
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 32'hFFFF_FFFF);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 32'hFFFF_FFFF);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 32'hFFFF_FFFF);
    apb_write(sobel_pkg::REG_ABSOLUTE_MODE, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) check_register(sobel_pkg::reg_index_t'(i));
  endtask

  // Full-scale gradients of both signs, a flat zero, and magnitude of a negative y edge.
  task automatic test_full_scale_edges();
    wait_idle();
    sender_idle = 1;
    receiver_idle = 1;
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 5);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 3);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 0);
    apb_write(sobel_pkg::REG_ABSOLUTE_MODE, 0);
    for (int k = 0; k < 15; k++) push_pixel((k % 5 == 2) ? 8'hFF : 8'h00, k == 0);
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 3);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 1);
    apb_write(sobel_pkg::REG_ABSOLUTE_MODE, 1);
    for (int k = 0; k < 9; k++) push_pixel((k < 3) ? 8'hFF : 8'h00, k == 0);
  endtask

  // Sizes below the minimum and above the maximum, and the wrap after a frame.
  task automatic test_size_clamp();
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 1);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 2);
    apb_write(sobel_pkg::REG_ABSOLUTE_MODE, 0);
    push_random_pixels(18, 1'b1);
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 0);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 0);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 0);
    push_random_pixels(9, 1'b0);
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 2047);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 3);
    apb_write(sobel_pkg::REG_ABSOLUTE_MODE, 1);
    push_random_pixels(64, 1'b1);
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 0);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 8191);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 1);
    push_random_pixels(48, 1'b1);
  endtask

  // Shrink width and height while the position lies outside the new frame.
  task automatic test_shrunk_size();
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 12);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 10);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 0);
    apb_write(sobel_pkg::REG_ABSOLUTE_MODE, 0);
    push_random_pixels(5 * 12 + 5, 1'b1);
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 4);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 6);
    push_random_pixels(20, 1'b0);
    wait_idle();
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 3);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 3);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 1);
    push_random_pixels(15, 1'b0);
  endtask

  // Hold the result side off so the block fills and stalls pix_in.
  task automatic test_backpressure();
    wait_idle();
    sender_idle = 0;
    receiver_idle = 0;
    apb_write(sobel_pkg::REG_IMAGE_WIDTH, 16);
    apb_write(sobel_pkg::REG_IMAGE_HEIGHT, 12);
    apb_write(sobel_pkg::REG_VERTICAL_MODE, 0);
    apb_write(sobel_pkg::REG_ABSOLUTE_MODE, 1);
    hold_off_cycles = 300;
    push_random_pixels(150, 1'b1);
    wait_idle();
    receiver_idle = 2;
    push_random_pixels(60, 1'b0);
  endtask

  task automatic test_random_frames();
    int sent;
    int r;
    int w;
    int h;
    int frames;
    int total;
    int frame_len;
    logic first_start;
    logic fs;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      wait_idle();
      r = $urandom_range(0, 99);
      if (r < 75) w = $urandom_range(3, 24);
      else if (r < 90) w = $urandom_range(25, 100);
      else w = $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0) apb_write(sobel_pkg::REG_IMAGE_WIDTH, w);
      h = ($urandom_range(0, 9) < 8) ? $urandom_range(3, 8) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) != 0) apb_write(sobel_pkg::REG_IMAGE_HEIGHT, h);
      if ($urandom_range(0, 1))
        apb_write(sobel_pkg::REG_VERTICAL_MODE, $urandom_range(0, 1));
      if ($urandom_range(0, 1))
        apb_write(sobel_pkg::REG_ABSOLUTE_MODE, $urandom_range(0, 1));
      sender_idle = $urandom_range(0, 2);
      receiver_idle = $urandom_range(0, 2);
      frame_len = eff_size(32'(cfg_width), sobel_pkg::MAX_WIDTH) *
                  eff_size(32'(cfg_height), sobel_pkg::MAX_HEIGHT);
      frames = $urandom_range(1, 3);
      total = frames * frame_len;
      if (total > 600) total = 600;
      // cut some phases short mid-frame
      if ($urandom_range(0, 4) == 0) total = $urandom_range(1, total);
      first_start = ($urandom_range(0, 3) != 0);
      for (int k = 0; k < total; k++) begin
        if (k % frame_len == 0) fs = (k == 0) ? first_start : ($urandom_range(0, 1) == 1);
        else fs = ($urandom_range(0, 63) == 0);
        push_pixel(sobel_pkg::pixel_t'($urandom_range(0, 255)), fs);
      end
      sent += total;
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    pix_ch.frame_start <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_access();
    test_full_scale_edges();
    test_size_clamp();
    test_shrunk_size();
    test_backpressure();
    test_random_frames();
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
